FILE: sv/lra_pkg.sv
// shared types and constants for the layer ring allocator
`timescale 1ns / 1ps
package lra_pkg;

    localparam int SLOTS_DEF     = 16;
    localparam int ADDR_BITS_DEF = 32;
    localparam logic [31:0] REGION_RESET = 32'd1048576;

    typedef enum logic [1:0] {
        MD_PREPARE = 2'd0,
        MD_COMMIT  = 2'd1,
        MD_RETIRE  = 2'd2,
        MD_ADVANCE = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        PH_FREE = 2'd0,
        PH_PREP = 2'd1,
        PH_ACT  = 2'd2,
        PH_RET  = 2'd3
    } t_phase;

    typedef enum logic [2:0] {
        STS_OK          = 3'd0,
        STS_TOO_LARGE   = 3'd1,
        STS_ALREADY     = 3'd2,
        STS_NONE_PREP   = 3'd3,
        STS_NONE_ACTIVE = 3'd4,
        STS_NO_ROOM     = 3'd5,
        STS_TABLE_FULL  = 3'd6
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_WRA,
        S_WRC,
        S_RUN,
        S_HEAD,
        S_REUSE,
        S_RETS,
        S_SUCC,
        S_GAP,
        S_PLACE,
        S_FIN,
        S_OUT
    } t_state;

    typedef struct packed {
        logic        en;
        logic        full;
    } t_wr_ctl;

    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] size_bytes;
    } t_in;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] placed_offset;
        logic [31:0] layer_tag;
        logic [31:0] head_position;
        logic        active_valid;
        logic [31:0] act_offset;
        logic [31:0] active_length;
        logic [31:0] committed_count;
        logic [31:0] retired_count;
        logic [4:0]  slots_used;
    } t_out;

endpackage

FILE: sv/lra_slot_mem.sv
// slot table storage: start, length and phase per slot, one read and one write port
`timescale 1ns / 1ps
module lra_slot_mem #(
    parameter int SLOTS = lra_pkg::SLOTS_DEF,
    parameter int AW    = lra_pkg::ADDR_BITS_DEF,
    parameter int IW    = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
    input  logic                i_clk,
    input  logic [IW-1:0]       i_rd_idx,
    input  lra_pkg::t_wr_ctl    i_wr_ctl,
    input  logic [IW-1:0]       i_wr_idx,
    input  logic [AW-1:0]       i_wr_start,
    input  logic [AW-1:0]       i_wr_len,
    input  lra_pkg::t_phase     i_wr_phase,
    output logic [AW-1:0]       o_rd_start,
    output logic [AW-1:0]       o_rd_len,
    output lra_pkg::t_phase     o_rd_phase
);
    import lra_pkg::*;

    logic [AW-1:0] r_start [SLOTS];
    logic [AW-1:0] r_len   [SLOTS];
    t_phase        r_phase [SLOTS];

    always_ff @(posedge i_clk) begin
        if (i_wr_ctl.en) begin
            r_phase[i_wr_idx] <= i_wr_phase;
            if (i_wr_ctl.full) begin
                r_start[i_wr_idx] <= i_wr_start;
                r_len[i_wr_idx]   <= i_wr_len;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        o_rd_start <= r_start[i_rd_idx];
        o_rd_len   <= r_len[i_rd_idx];
        o_rd_phase <= r_phase[i_rd_idx];
    end

endmodule

FILE: sv/lra_ring_chk.sv
// circular overlap check of a candidate placement against the active layer
`timescale 1ns / 1ps
module lra_ring_chk #(
    parameter int AW = lra_pkg::ADDR_BITS_DEF
) (
    input  logic [AW-1:0] i_region,
    input  logic          i_act_v,
    input  logic [AW-1:0] i_act_start,
    input  logic [AW-1:0] i_act_len,
    input  logic [AW:0]   i_off,
    input  logic [AW-1:0] i_len,
    output logic          o_safe
);
    import lra_pkg::*;

    localparam int W = AW + 2;

    function automatic logic seg_ov(logic [W-1:0] s1, logic [W-1:0] e1,
                                    logic [W-1:0] s2, logic [W-1:0] e2);
        seg_ov = !(e1 <= s1 || e2 <= s2) && (s1 < e2) && (s2 < e1);
    endfunction

    logic [W-1:0] w_r, w_as, w_ae, w_a1, w_a2, w_bs, w_be, w_b1, w_b2;
    logic         w_aw, w_bw, w_ov;

    always_comb begin
        w_r  = W'(i_region);
        w_as = W'(i_off);
        w_ae = w_as + W'(i_len);
        w_bs = W'(i_act_start);
        w_be = w_bs + W'(i_act_len);
        w_aw = w_ae > w_r;
        w_bw = w_be > w_r;
        w_a1 = w_aw ? w_r : w_ae;
        w_a2 = w_aw ? (w_ae - w_r) : '0;
        w_b1 = w_bw ? w_r : w_be;
        w_b2 = w_bw ? (w_be - w_r) : '0;
        w_ov = seg_ov(w_as, w_a1, w_bs, w_b1)
            || (w_bw && seg_ov(w_as, w_a1, '0, w_b2))
            || (w_aw && seg_ov('0, w_a2, w_bs, w_b1))
            || (w_aw && w_bw && seg_ov('0, w_a2, '0, w_b2));
        o_safe = !i_act_v || !w_ov;
    end

endmodule

FILE: sv/layer_ring_allocator_core.sv
// slot table allocator for a circular region: sequencer, counters and result register
//
//  channel | signals                                   | moves
//  --------+-------------------------------------------+-----------------------------
//  input   | i_in_valid / o_in_ready / i_in_data       | mode and layer size
//  output  | o_out_valid / i_out_ready / o_out_data    | status, placement, totals
//  config  | i_cfg_valid / o_cfg_ready / i_cfg_data    | region size
//
// one item at a time; each slot visit reads through the single registered read port
// prepare time is dominated by the ordered gap walk, which finds each next range by start
// with a full pass over the table
// reset clears counters, fill and control; slot contents need none
// a result held in the output register stalls only the return to idle
`timescale 1ns / 1ps
module layer_ring_allocator_core #(
    parameter int SLOTS     = lra_pkg::SLOTS_DEF,
    parameter int ADDR_BITS = lra_pkg::ADDR_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  lra_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output lra_pkg::t_out o_out_data,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [31:0]   i_cfg_data
);
    import lra_pkg::*;

    localparam int AW = ADDR_BITS;
    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int FW = $clog2(SLOTS + 1);

    t_state        r_state, n_state;
    logic [AW-1:0] r_region;
    t_mode         r_mode, n_mode;
    logic [AW-1:0] r_req, n_req;
    t_status       r_status, n_status;
    logic [FW-1:0] r_idx, n_idx;
    logic          r_half, n_half;
    logic [FW-1:0] r_fill, n_fill;
    logic [AW-1:0] r_head, n_head;
    logic [31:0]   r_next_tag, n_next_tag;
    logic [31:0]   r_commit, n_commit;
    logic [31:0]   r_retire, n_retire;
    logic          r_prep_v, n_prep_v;
    logic [FW-1:0] r_prep_i, n_prep_i;
    logic          r_act_v, n_act_v;
    logic [FW-1:0] r_act_i, n_act_i;
    logic [AW-1:0] r_act_s, n_act_s;
    logic [AW-1:0] r_act_l, n_act_l;
    logic [AW-1:0] r_cand, n_cand;
    logic          r_lt_v, n_lt_v;
    logic [AW-1:0] r_lt_s, n_lt_s;
    logic [AW:0]   r_lt_e, n_lt_e;
    logic          r_ge_v, n_ge_v;
    logic [AW-1:0] r_ge_s, n_ge_s;
    logic          r_cur_v, n_cur_v;
    logic [AW-1:0] r_cur_s, n_cur_s;
    logic [AW:0]   r_cur_e, n_cur_e;
    logic [FW-1:0] r_cur_i, n_cur_i;
    logic          r_bst_v, n_bst_v;
    logic [AW-1:0] r_bst_s, n_bst_s;
    logic [AW:0]   r_bst_e, n_bst_e;
    logic [FW-1:0] r_bst_i, n_bst_i;
    logic [AW-1:0] r_off, n_off;
    logic          r_reuse_v, n_reuse_v;
    logic [FW-1:0] r_reuse_i, n_reuse_i;
    logic [AW-1:0] r_placed, n_placed;
    logic [31:0]   r_tag_out, n_tag_out;
    logic          r_ovalid, n_ovalid;
    t_out          r_out, n_out;

    t_wr_ctl       w_wr_ctl;
    logic [IW-1:0] w_wr_idx;
    t_phase        w_wr_phase;
    logic [AW-1:0] w_rs, w_rl;
    t_phase        w_rp;
    logic [AW:0]   w_re, w_reg1, w_req1, w_chk_off, w_off_end, w_rs_end, w_cur_end;
    logic [AW-1:0] w_free;
    logic [AW:0]   w_gap;
    logic          w_safe, w_done;

    lra_slot_mem #(.SLOTS(SLOTS), .AW(AW), .IW(IW)) u_mem (
        .i_clk      (i_clk),
        .i_rd_idx   (r_idx[IW-1:0]),
        .i_wr_ctl   (w_wr_ctl),
        .i_wr_idx   (w_wr_idx),
        .i_wr_start (r_off),
        .i_wr_len   (r_req),
        .i_wr_phase (w_wr_phase),
        .o_rd_start (w_rs),
        .o_rd_len   (w_rl),
        .o_rd_phase (w_rp)
    );

    lra_ring_chk #(.AW(AW)) u_chk (
        .i_region    (r_region),
        .i_act_v     (r_act_v),
        .i_act_start (r_act_s),
        .i_act_len   (r_act_l),
        .i_off       (w_chk_off),
        .i_len       (r_req),
        .o_safe      (w_safe)
    );

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;

    always_comb begin
        w_re      = {1'b0, w_rs} + {1'b0, w_rl};
        w_reg1    = {1'b0, r_region};
        w_req1    = {1'b0, r_req};
        w_off_end = {1'b0, r_off} + w_req1;
        w_rs_end  = {1'b0, w_rs} + w_req1;
        w_cur_end = r_cur_e + w_req1;
        w_done    = (r_idx >= r_fill);
        // free run from the head candidate
        if (r_lt_v && r_lt_e > {1'b0, r_cand}) begin
            w_free = '0;
        end else if (r_ge_v) begin
            w_free = r_ge_s - r_cand;
        end else begin
            w_free = (r_region > r_cand) ? (r_region - r_cand) : '0;
        end
        w_gap = ({1'b0, r_bst_s} > r_cur_e) ? ({1'b0, r_bst_s} - r_cur_e) : '0;
        unique case (r_state)
            S_HEAD:  w_chk_off = {1'b0, r_cand};
            S_RETS:  w_chk_off = {1'b0, w_rs};
            S_GAP:   w_chk_off = r_cur_v ? r_cur_e : '0;
            default: w_chk_off = '0;
        endcase
    end

    always_comb begin
        n_state    = r_state;
        n_mode     = r_mode;
        n_req      = r_req;
        n_status   = r_status;
        n_idx      = r_idx;
        n_half     = r_half;
        n_fill     = r_fill;
        n_head     = r_head;
        n_next_tag = r_next_tag;
        n_commit   = r_commit;
        n_retire   = r_retire;
        n_prep_v   = r_prep_v;
        n_prep_i   = r_prep_i;
        n_act_v    = r_act_v;
        n_act_i    = r_act_i;
        n_act_s    = r_act_s;
        n_act_l    = r_act_l;
        n_cand     = r_cand;
        n_lt_v     = r_lt_v;
        n_lt_s     = r_lt_s;
        n_lt_e     = r_lt_e;
        n_ge_v     = r_ge_v;
        n_ge_s     = r_ge_s;
        n_cur_v    = r_cur_v;
        n_cur_s    = r_cur_s;
        n_cur_e    = r_cur_e;
        n_cur_i    = r_cur_i;
        n_bst_v    = r_bst_v;
        n_bst_s    = r_bst_s;
        n_bst_e    = r_bst_e;
        n_bst_i    = r_bst_i;
        n_off      = r_off;
        n_reuse_v  = r_reuse_v;
        n_reuse_i  = r_reuse_i;
        n_placed   = r_placed;
        n_tag_out  = r_tag_out;
        n_ovalid   = r_ovalid && !i_out_ready;
        n_out      = r_out;
        w_wr_ctl   = '0;
        w_wr_idx   = '0;
        w_wr_phase = PH_PREP;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_mode    = t_mode'(i_in_data.mode);
                    n_req     = AW'(i_in_data.size_bytes);
                    n_status  = STS_OK;
                    n_placed  = '0;
                    n_tag_out = '0;
                    n_prep_v  = 1'b0;
                    n_act_v   = 1'b0;
                    n_idx     = '0;
                    n_half    = 1'b0;
                    if (t_mode'(i_in_data.mode) == MD_PREPARE &&
                        AW'(i_in_data.size_bytes) > r_region) begin
                        n_status = STS_TOO_LARGE;
                        n_state  = S_FIN;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (!r_half) begin
                    if (w_done) n_state = S_DECIDE;
                    else        n_half  = 1'b1;
                end else begin
                    if (w_rp == PH_PREP && !r_prep_v) begin
                        n_prep_v = 1'b1;
                        n_prep_i = r_idx;
                    end
                    if (w_rp == PH_ACT && !r_act_v) begin
                        n_act_v = 1'b1;
                        n_act_i = r_idx;
                        n_act_s = w_rs;
                        n_act_l = w_rl;
                    end
                    n_idx  = r_idx + 1'b1;
                    n_half = 1'b0;
                end
            end
            S_DECIDE: begin
                n_idx  = '0;
                n_half = 1'b0;
                unique case (r_mode)
                    MD_PREPARE: begin
                        if (r_prep_v) begin
                            n_status = STS_ALREADY;
                            n_act_v  = 1'b0;
                            n_state  = S_FIN;
                        end else begin
                            n_cand  = ({1'b0, r_head} + w_req1 <= w_reg1) ? r_head : '0;
                            n_lt_v  = 1'b0;
                            n_ge_v  = 1'b0;
                            n_state = S_RUN;
                        end
                    end
                    MD_COMMIT: begin
                        if (!r_prep_v) begin
                            n_status = STS_NONE_PREP;
                            n_act_v  = 1'b0;
                            n_state  = S_FIN;
                        end else begin
                            n_state = S_WRA;
                        end
                    end
                    MD_RETIRE: begin
                        if (!r_act_v) begin
                            n_status = STS_NONE_ACTIVE;
                            n_state  = S_FIN;
                        end else begin
                            n_state = S_WRA;
                        end
                    end
                    MD_ADVANCE: n_state = S_WRA;
                    default:    n_state = S_WRA;
                endcase
            end
            S_WRA: begin
                if ((r_mode == MD_RETIRE || r_mode == MD_ADVANCE) && r_act_v) begin
                    w_wr_ctl.en = 1'b1;
                    w_wr_idx    = r_act_i[IW-1:0];
                    w_wr_phase  = PH_RET;
                    n_retire    = r_retire + 32'd1;
                end
                n_state = S_WRC;
            end
            S_WRC: begin
                if ((r_mode == MD_COMMIT || r_mode == MD_ADVANCE) && r_prep_v) begin
                    w_wr_ctl.en = 1'b1;
                    w_wr_idx    = r_prep_i[IW-1:0];
                    w_wr_phase  = PH_ACT;
                    n_commit    = r_commit + 32'd1;
                end
                n_act_v = 1'b0;
                n_idx   = '0;
                n_state = S_FIN;
            end
            S_RUN: begin
                if (!r_half) begin
                    if (w_done) n_state = S_HEAD;
                    else        n_half  = 1'b1;
                end else begin
                    if (w_rl != '0) begin
                        if (w_rs < r_cand) begin
                            // later slot wins a tie on start
                            if (!r_lt_v || w_rs >= r_lt_s) begin
                                n_lt_v = 1'b1;
                                n_lt_s = w_rs;
                                n_lt_e = w_re;
                            end
                        end else if (!r_ge_v || w_rs < r_ge_s) begin
                            n_ge_v = 1'b1;
                            n_ge_s = w_rs;
                        end
                    end
                    n_idx  = r_idx + 1'b1;
                    n_half = 1'b0;
                end
            end
            S_HEAD: begin
                n_idx     = '0;
                n_half    = 1'b0;
                n_reuse_v = 1'b0;
                if (w_free >= r_req && w_safe) begin
                    n_off   = r_cand;
                    n_state = S_REUSE;
                end else begin
                    n_state = S_RETS;
                end
            end
            S_REUSE: begin
                if (!r_half) begin
                    if (w_done) n_state = S_PLACE;
                    else        n_half  = 1'b1;
                end else begin
                    n_idx  = r_idx + 1'b1;
                    n_half = 1'b0;
                    if (w_rp == PH_RET && w_rs <= r_off && w_re >= w_off_end &&
                        w_rs_end <= w_reg1) begin
                        n_reuse_v = 1'b1;
                        n_reuse_i = r_idx;
                        n_state   = S_PLACE;
                    end
                end
            end
            S_RETS: begin
                if (!r_half) begin
                    if (w_done) begin
                        n_cur_v = 1'b0;
                        n_bst_v = 1'b0;
                        n_idx   = '0;
                        n_state = S_SUCC;
                    end else begin
                        n_half = 1'b1;
                    end
                end else begin
                    n_idx  = r_idx + 1'b1;
                    n_half = 1'b0;
                    if (w_rp == PH_RET && w_rl >= r_req && w_safe && w_rs_end <= w_reg1) begin
                        n_off     = w_rs;
                        n_reuse_v = 1'b1;
                        n_reuse_i = r_idx;
                        n_state   = S_PLACE;
                    end
                end
            end
            S_SUCC: begin
                // next range after the current one in (start, slot) order
                if (!r_half) begin
                    if (w_done) n_state = S_GAP;
                    else        n_half  = 1'b1;
                end else begin
                    if (w_rl != '0 &&
                        (!r_cur_v || w_rs > r_cur_s || (w_rs == r_cur_s && r_idx > r_cur_i)) &&
                        (!r_bst_v || w_rs < r_bst_s)) begin
                        n_bst_v = 1'b1;
                        n_bst_s = w_rs;
                        n_bst_e = w_re;
                        n_bst_i = r_idx;
                    end
                    n_idx  = r_idx + 1'b1;
                    n_half = 1'b0;
                end
            end
            S_GAP: begin
                n_idx  = '0;
                n_half = 1'b0;
                if (!r_cur_v) begin
                    if (!r_bst_v) begin
                        n_off   = '0;
                        n_state = S_PLACE;
                    end else if (r_bst_s >= r_req && w_safe) begin
                        n_off   = '0;
                        n_state = S_PLACE;
                    end else begin
                        n_cur_v = 1'b1;
                        n_cur_s = r_bst_s;
                        n_cur_e = r_bst_e;
                        n_cur_i = r_bst_i;
                        n_bst_v = 1'b0;
                        n_state = S_SUCC;
                    end
                end else if (r_bst_v) begin
                    if (w_gap >= w_req1 && w_safe && w_cur_end <= w_reg1) begin
                        n_off   = r_cur_e[AW-1:0];
                        n_state = S_PLACE;
                    end else begin
                        n_cur_s = r_bst_s;
                        n_cur_e = r_bst_e;
                        n_cur_i = r_bst_i;
                        n_bst_v = 1'b0;
                        n_state = S_SUCC;
                    end
                end else begin
                    // tail gap after the last range
                    if (r_cur_e < w_reg1 && (w_reg1 - r_cur_e) >= w_req1 && w_safe) begin
                        n_off   = r_cur_e[AW-1:0];
                        n_state = S_PLACE;
                    end else begin
                        n_status = STS_NO_ROOM;
                        n_act_v  = 1'b0;
                        n_state  = S_FIN;
                    end
                end
            end
            S_PLACE: begin
                n_idx   = '0;
                n_half  = 1'b0;
                n_act_v = 1'b0;
                n_state = S_FIN;
                if (!r_reuse_v && r_fill >= FW'(SLOTS)) begin
                    n_status = STS_TABLE_FULL;
                end else begin
                    w_wr_ctl.en   = 1'b1;
                    w_wr_ctl.full = 1'b1;
                    w_wr_phase    = PH_PREP;
                    if (r_reuse_v) begin
                        w_wr_idx = r_reuse_i[IW-1:0];
                    end else begin
                        w_wr_idx = r_fill[IW-1:0];
                        n_fill   = r_fill + 1'b1;
                    end
                    n_head     = (w_off_end >= w_reg1) ? '0 : w_off_end[AW-1:0];
                    n_placed   = r_off;
                    n_tag_out  = r_next_tag;
                    n_next_tag = r_next_tag + 32'd1;
                end
            end
            S_FIN: begin
                if (!r_half) begin
                    if (w_done) n_state = S_OUT;
                    else        n_half  = 1'b1;
                end else begin
                    n_idx  = r_idx + 1'b1;
                    n_half = 1'b0;
                    if (w_rp == PH_ACT) begin
                        n_act_v = 1'b1;
                        n_act_s = w_rs;
                        n_act_l = w_rl;
                        n_state = S_OUT;
                    end
                end
            end
            S_OUT: begin
                if (!r_ovalid || i_out_ready) begin
                    n_ovalid              = 1'b1;
                    n_out.status          = r_status;
                    n_out.placed_offset   = 32'(r_placed);
                    n_out.layer_tag       = r_tag_out;
                    n_out.head_position   = 32'(r_head);
                    n_out.active_valid    = r_act_v;
                    n_out.act_offset      = r_act_v ? 32'(r_act_s) : '0;
                    n_out.active_length   = r_act_v ? 32'(r_act_l) : '0;
                    n_out.committed_count = r_commit;
                    n_out.retired_count   = r_retire;
                    n_out.slots_used      = 5'(r_fill);
                    n_state               = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_region   <= AW'(REGION_RESET);
            r_fill     <= '0;
            r_head     <= '0;
            r_next_tag <= '0;
            r_commit   <= '0;
            r_retire   <= '0;
            r_ovalid   <= 1'b0;
            r_idx      <= '0;
            r_half     <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_fill     <= n_fill;
            r_head     <= n_head;
            r_next_tag <= n_next_tag;
            r_commit   <= n_commit;
            r_retire   <= n_retire;
            r_ovalid   <= n_ovalid;
            r_idx      <= n_idx;
            r_half     <= n_half;
            if (i_cfg_valid) begin
                r_region <= AW'(i_cfg_data);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode    <= n_mode;
        r_req     <= n_req;
        r_status  <= n_status;
        r_prep_v  <= n_prep_v;
        r_prep_i  <= n_prep_i;
        r_act_v   <= n_act_v;
        r_act_i   <= n_act_i;
        r_act_s   <= n_act_s;
        r_act_l   <= n_act_l;
        r_cand    <= n_cand;
        r_lt_v    <= n_lt_v;
        r_lt_s    <= n_lt_s;
        r_lt_e    <= n_lt_e;
        r_ge_v    <= n_ge_v;
        r_ge_s    <= n_ge_s;
        r_cur_v   <= n_cur_v;
        r_cur_s   <= n_cur_s;
        r_cur_e   <= n_cur_e;
        r_cur_i   <= n_cur_i;
        r_bst_v   <= n_bst_v;
        r_bst_s   <= n_bst_s;
        r_bst_e   <= n_bst_e;
        r_bst_i   <= n_bst_i;
        r_off     <= n_off;
        r_reuse_v <= n_reuse_v;
        r_reuse_i <= n_reuse_i;
        r_placed  <= n_placed;
        r_tag_out <= n_tag_out;
        r_out     <= n_out;
    end

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FW'(SLOTS))
        else $error("slot fill beyond table size");

    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input taken while an item is in progress");

    a_write_states: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr_ctl.en |-> (r_state == S_WRA || r_state == S_WRC || r_state == S_PLACE))
        else $error("slot write outside an update step");

    a_full_write_on_place: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr_ctl.full |-> (r_state == S_PLACE && w_wr_ctl.en))
        else $error("full slot write outside placement");

    a_head_in_region: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PLACE && r_status == STS_OK && !(!r_reuse_v && r_fill >= FW'(SLOTS)))
        |=> (r_head < r_region || r_head == '0))
        else $error("write head left the region");

endmodule

FILE: bench/tb_top.sv
// testbench for the layer ring allocator: random stimulus, predictor and result checks
`timescale 1ns / 1ps
module tb_top;
    import lra_pkg::*;

    localparam int NSLOT = SLOTS_DEF;
    localparam int SETTLE_CYCLES = 1000;

    logic          i_clk;
    logic          i_rst_n;
    logic          in_valid;
    logic          in_ready;
    t_in           in_data;
    logic          out_valid;
    logic          out_ready;
    t_out          out_data;
    logic          cfg_valid;
    logic          cfg_ready;
    logic [31:0]   cfg_data;

    layer_ring_allocator_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // ---------------- allocator predictor ----------------
    longint unsigned region_bytes;
    longint unsigned tbl_start [NSLOT];
    longint unsigned tbl_len   [NSLOT];
    logic [31:0]     tbl_tag   [NSLOT];
    t_phase          tbl_phase [NSLOT];
    int unsigned     tbl_fill;
    longint unsigned head_pos;
    logic [31:0]     tag_next;
    logic [31:0]     commits;
    logic [31:0]     retires;
    longint unsigned rng_s [NSLOT];
    longint unsigned rng_e [NSLOT];

    function automatic longint unsigned sat_sub(longint unsigned a, longint unsigned b);
        return a > b ? a - b : 0;
    endfunction

    function automatic int first_in_phase(t_phase ph);
        for (int i = 0; i < tbl_fill; i++)
            if (tbl_phase[i] == ph) return i;
        return -1;
    endfunction

    // occupied ranges sorted by start, ties keep table order
    function automatic int sort_ranges();
        int n;
        int j;
        n = 0;
        for (int i = 0; i < tbl_fill; i++) begin
            if (tbl_len[i] == 0) continue;
            j = n;
            while (j > 0 && rng_s[j-1] > tbl_start[i]) begin
                rng_s[j] = rng_s[j-1];
                rng_e[j] = rng_e[j-1];
                j--;
            end
            rng_s[j] = tbl_start[i];
            rng_e[j] = tbl_start[i] + tbl_len[i];
            n++;
        end
        return n;
    endfunction

    function automatic longint unsigned free_span(longint unsigned off);
        int n;
        int k;
        n = sort_ranges();
        k = 0;
        if (n == 0) return sat_sub(region_bytes, off);
        while (k < n && rng_s[k] < off) k++;
        if (k > 0 && rng_e[k-1] > off) return 0;
        if (k < n) return rng_s[k] - off;
        return sat_sub(region_bytes, off);
    endfunction

    function automatic bit seg_hit(longint unsigned s1, longint unsigned e1,
                                   longint unsigned s2, longint unsigned e2);
        if (e1 <= s1 || e2 <= s2) return 0;
        return s1 < e2 && s2 < e1;
    endfunction

    function automatic bit ring_hit(longint unsigned as, longint unsigned al,
                                    longint unsigned bs, longint unsigned bl);
        longint unsigned ae;
        longint unsigned be;
        longint unsigned a1;
        longint unsigned a2;
        longint unsigned b1;
        longint unsigned b2;
        bit aw;
        bit bw;
        ae = as + al;
        be = bs + bl;
        aw = ae > region_bytes;
        bw = be > region_bytes;
        a1 = aw ? region_bytes : ae;
        a2 = aw ? ae - region_bytes : 0;
        b1 = bw ? region_bytes : be;
        b2 = bw ? be - region_bytes : 0;
        if (seg_hit(as, a1, bs, b1)) return 1;
        if (bw && seg_hit(as, a1, 0, b2)) return 1;
        if (aw && seg_hit(0, a2, bs, b1)) return 1;
        if (aw && bw && seg_hit(0, a2, 0, b2)) return 1;
        return 0;
    endfunction

    function automatic bit clear_of_active(int act, longint unsigned off,
                                           longint unsigned len);
        if (act < 0) return 1;
        return !ring_hit(off, len, tbl_start[act], tbl_len[act]);
    endfunction

    function automatic int retired_cover(longint unsigned off, longint unsigned req);
        for (int i = 0; i < tbl_fill; i++) begin
            if (tbl_phase[i] != PH_RET) continue;
            if (tbl_start[i] <= off && tbl_start[i] + tbl_len[i] >= off + req &&
                tbl_start[i] + req <= region_bytes)
                return i;
        end
        return -1;
    endfunction

    function automatic bit find_place(longint unsigned req, output longint unsigned off,
                                      output int reuse);
        int act;
        int n;
        act = first_in_phase(PH_ACT);
        reuse = -1;
        off = 0;
        if (head_pos + req <= region_bytes) begin
            if (free_span(head_pos) >= req && clear_of_active(act, head_pos, req)) begin
                off = head_pos;
                reuse = retired_cover(head_pos, req);
                return 1;
            end
        end else begin
            if (free_span(0) >= req && clear_of_active(act, 0, req)) begin
                reuse = retired_cover(0, req);
                return 1;
            end
        end
        for (int i = 0; i < tbl_fill; i++) begin
            if (tbl_phase[i] == PH_RET && tbl_len[i] >= req &&
                clear_of_active(act, tbl_start[i], req) &&
                tbl_start[i] + req <= region_bytes) begin
                off = tbl_start[i];
                reuse = i;
                return 1;
            end
        end
        n = sort_ranges();
        if (n == 0) return 1;
        if (rng_s[0] >= req && clear_of_active(act, 0, req)) return 1;
        for (int i = 0; i + 1 < n; i++) begin
            if (sat_sub(rng_s[i+1], rng_e[i]) >= req && clear_of_active(act, rng_e[i], req) &&
                rng_e[i] + req <= region_bytes) begin
                off = rng_e[i];
                return 1;
            end
        end
        if (rng_e[n-1] < region_bytes && region_bytes - rng_e[n-1] >= req &&
            clear_of_active(act, rng_e[n-1], req)) begin
            off = rng_e[n-1];
            return 1;
        end
        return 0;
    endfunction

    function automatic t_out alloc_step(t_in it);
        t_out r;
        t_status sts;
        longint unsigned req;
        longint unsigned off;
        longint unsigned placed;
        logic [31:0] tag;
        int reuse;
        int k;
        int idx;
        req = it.size_bytes;
        sts = STS_OK;
        placed = 0;
        tag = '0;
        case (t_mode'(it.mode))
            MD_PREPARE: begin
                if (req > region_bytes) sts = STS_TOO_LARGE;
                else if (first_in_phase(PH_PREP) >= 0) sts = STS_ALREADY;
                else if (!find_place(req, off, reuse)) sts = STS_NO_ROOM;
                else if (reuse < 0 && tbl_fill >= NSLOT) sts = STS_TABLE_FULL;
                else begin
                    if (reuse >= 0) idx = reuse;
                    else begin
                        idx = tbl_fill;
                        tbl_fill++;
                    end
                    tbl_start[idx] = off;
                    tbl_len[idx] = req;
                    tbl_tag[idx] = tag_next;
                    tbl_phase[idx] = PH_PREP;
                    head_pos = off + req;
                    if (head_pos >= region_bytes) head_pos = 0;
                    placed = off;
                    tag = tag_next;
                    tag_next++;
                end
            end
            MD_COMMIT: begin
                k = first_in_phase(PH_PREP);
                if (k < 0) sts = STS_NONE_PREP;
                else begin
                    tbl_phase[k] = PH_ACT;
                    commits++;
                end
            end
            MD_RETIRE: begin
                k = first_in_phase(PH_ACT);
                if (k < 0) sts = STS_NONE_ACTIVE;
                else begin
                    tbl_phase[k] = PH_RET;
                    retires++;
                end
            end
            default: begin
                k = first_in_phase(PH_ACT);
                if (k >= 0) begin
                    tbl_phase[k] = PH_RET;
                    retires++;
                end
                k = first_in_phase(PH_PREP);
                if (k >= 0) begin
                    tbl_phase[k] = PH_ACT;
                    commits++;
                end
            end
        endcase
        k = first_in_phase(PH_ACT);
        r.status          = sts;
        r.placed_offset   = placed[31:0];
        r.layer_tag       = tag;
        r.head_position   = head_pos[31:0];
        r.active_valid    = k >= 0;
        r.act_offset      = k >= 0 ? tbl_start[k][31:0] : '0;
        r.active_length   = k >= 0 ? tbl_len[k][31:0] : '0;
        r.committed_count = commits;
        r.retired_count   = retires;
        r.slots_used      = tbl_fill[4:0];
        return r;
    endfunction

    // ---------------- stimulus, driver, receiver, monitor ----------------
    t_in  pending_q[$];
    t_out expected_q[$];
    int   fail_count;
    bit   in_taken;
    int   send_gap;
    int   recv_hold;
    bit   long_hold_req;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 95) return $urandom_range(1, 4);
        return $urandom_range(20, 80);
    endfunction

    function automatic logic [31:0] pick_size();
        int r;
        longint unsigned top;
        r = $urandom_range(0, 99);
        top = region_bytes / 6;
        if (top == 0) top = 1;
        if (top > 32'hFFFF_FFFF) top = 32'hFFFF_FFFF;
        if (r < 5) return '0;
        if (r < 10) return region_bytes[31:0];
        if (r < 13) return 32'hFFFF_FFFF;
        if (r < 16) return region_bytes[31:0] + 32'd1;
        if (r < 19) return $urandom;
        return $urandom_range(1, int'(top[31:0] > 32'h7FFF_FFFF ? 32'h7FFF_FFFF : top[31:0]));
    endfunction

    task automatic push_item(t_mode m, logic [31:0] sz);
        t_in it;
        it.mode = m;
        it.size_bytes = sz;
        pending_q = {pending_q, it};
    endtask

    task automatic push_random(int count);
        int r;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(0, 99);
            if (r < 40) push_item(MD_PREPARE, pick_size());
            else if (r < 62) push_item(MD_COMMIT, $urandom);
            else if (r < 80) push_item(MD_RETIRE, $urandom);
            else push_item(MD_ADVANCE, $urandom);
        end
    endtask

    task automatic wait_idle();
        while (pending_q.size() != 0 || in_valid || expected_q.size() != 0)
            @(posedge i_clk);
        // margin before the region is rewritten
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_region(logic [31:0] value);
        @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        region_bytes = value;
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    always @(negedge i_clk) begin
        t_in nx;
        logic nv;
        nx = in_data;
        nv = in_valid;
        if (!i_rst_n) begin
            nv = 1'b0;
        end else if (!in_valid || in_taken) begin
            in_taken = 1'b0;
            if (send_gap > 0) begin
                send_gap--;
                nv = 1'b0;
            end else if (pending_q.size() != 0) begin
                nx = pending_q.pop_front();
                nv = 1'b1;
                send_gap = pick_gap();
            end else begin
                nv = 1'b0;
            end
        end
        in_valid <= nv;
        in_data  <= nx;
    end

    always @(negedge i_clk) begin
        if (long_hold_req) begin
            long_hold_req = 1'b0;
            recv_hold = 3000;
        end
        if (recv_hold > 0) begin
            recv_hold--;
            out_ready <= 1'b0;
        end else if ($urandom_range(0, 99) < 8) begin
            recv_hold = pick_gap();
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_out exp_r;
        if (i_rst_n && in_valid && in_ready) begin
            expected_q = {expected_q, alloc_step(in_data)};
            in_taken = 1'b1;
        end
        if (i_rst_n && out_valid && out_ready) begin
            if (expected_q.size() == 0) begin
                $error("result transfer with nothing expected");
                fail_count++;
            end else begin
                exp_r = expected_q.pop_front();
                check_field("status", exp_r.status, out_data.status);
                check_field("placed_offset", exp_r.placed_offset, out_data.placed_offset);
                check_field("layer_tag", exp_r.layer_tag, out_data.layer_tag);
                check_field("head_position", exp_r.head_position, out_data.head_position);
                check_field("active_valid", exp_r.active_valid, out_data.active_valid);
                check_field("act_offset", exp_r.act_offset, out_data.act_offset);
                check_field("active_length", exp_r.active_length, out_data.active_length);
                check_field("committed_count", exp_r.committed_count,
                            out_data.committed_count);
                check_field("retired_count", exp_r.retired_count, out_data.retired_count);
                check_field("slots_used", exp_r.slots_used, out_data.slots_used);
            end
        end
    end

    initial begin
        #50_000_000;
        $display("tb_top NOT OK");
        $finish;
    end

    initial begin
        i_rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        in_taken = 1'b0;
        send_gap = 0;
        recv_hold = 0;
        long_hold_req = 1'b0;
        fail_count = 0;
        region_bytes = REGION_RESET;
        tbl_fill = 0;
        head_pos = 0;
        tag_next = '0;
        commits = '0;
        retires = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: empty-table errors, extremes, wrap and already-preparing
        push_item(MD_COMMIT, 32'hFFFF_FFFF);
        push_item(MD_RETIRE, '0);
        push_item(MD_ADVANCE, '0);
        push_item(MD_PREPARE, 32'hFFFF_FFFF);
        push_item(MD_PREPARE, REGION_RESET + 32'd1);
        push_item(MD_PREPARE, '0);
        push_item(MD_PREPARE, 32'd16);
        push_item(MD_COMMIT, '0);
        push_item(MD_PREPARE, 32'd100);
        push_item(MD_ADVANCE, '0);
        push_item(MD_PREPARE, REGION_RESET);
        push_item(MD_PREPARE, 32'h0008_0000);
        push_item(MD_PREPARE, 32'h0008_0000);
        push_item(MD_RETIRE, '0);
        push_item(MD_COMMIT, '0);
        push_item(MD_PREPARE, 32'h0007_FF00);
        push_item(MD_ADVANCE, '0);
        push_item(MD_RETIRE, '0);
        push_item(MD_PREPARE, 32'd200);
        push_item(MD_PREPARE, 32'h5555_5555);
        push_random(230);
        wait_idle();

        write_region(32'd4096);
        push_random(40);
        long_hold_req = 1'b1;
        push_random(160);
        wait_idle();

        write_region(32'd1);
        push_random(60);
        wait_idle();

        write_region(32'hFFFF_FFFF);
        push_item(MD_PREPARE, 32'hFFFF_FFFF);
        push_item(MD_ADVANCE, '0);
        push_item(MD_PREPARE, 32'hAAAA_AAAA);
        push_random(150);
        wait_idle();

        // shrink under live slots: head may sit beyond the region end
        write_region(32'd300);
        push_random(100);
        wait_idle();

        if (fail_count == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule
